### sv/path_distance_decimator_unit_defines.svh
// assertion macros shared by the path distance decimator modules
`ifndef PATH_DISTANCE_DECIMATOR_UNIT_DEFINES_SVH
`define PATH_DISTANCE_DECIMATOR_UNIT_DEFINES_SVH

// condition must never hold outside reset
`define PDD_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PDD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/pdd_pkg.sv
// shared constants, types and state codes of the path distance decimator
package pdd_pkg;

   // parameter defaults
   localparam int MAX_POINTS_DEF = 65536;
   localparam int COORD_BITS_DEF = 32;
   localparam int DELTA_BITS_DEF = 24;

   // fixed field and port widths
   localparam int IDX_W      = 16;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 1;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_SPACING = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_LOOP    = 1'b1;

   // classification of one point as handed from front to back
   typedef struct packed {
      logic [IDX_W-1:0] index;
      logic             first;
      logic             last;
   } pdd_tag_type;

   // back end sequencer
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MULX,
      BK_MULY,
      BK_SUM,
      BK_ROOT,
      BK_ACCUM,
      BK_EMIT
   } pdd_back_state_type;

endpackage

### sv/pdd_fifo.sv
// short register queue between the front and back of the decimator
`include "path_distance_decimator_unit_defines.svh"

module pdd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   // pointer and fill count updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = slot_ff[rd_ptr_ff];
   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);

   `PDD_ASSERT_NEVER(a_no_push_full, clock, reset, push && full, "queue written while full")
   `PDD_ASSERT_NEVER(a_no_pop_empty, clock, reset, pop && empty, "queue read while empty")
   `PDD_ASSERT_NEXT(a_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1, "queue count did not grow on push")

endmodule

### sv/pdd_front.sv
// front end: takes points, tracks route position and forms saturated deltas
module pdd_front import pdd_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int DELTA_BITS = DELTA_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic signed [COORD_BITS-1:0] x_mm,
   input  logic signed [COORD_BITS-1:0] y_mm,
   input  logic                         route_last,
   input  logic                         q_full,
   output logic                         q_push,
   output logic [DELTA_BITS-1:0]        q_dx,
   output logic [DELTA_BITS-1:0]        q_dy,
   output pdd_tag_type                  q_tag
);

   localparam int AW = (COORD_BITS + 1 > DELTA_BITS + 1) ? COORD_BITS + 1 : DELTA_BITS + 1;
   localparam logic [AW-1:0] DMAX = {{(AW - DELTA_BITS){1'b0}}, {DELTA_BITS{1'b1}}};
   localparam int IDX_CAP_I = (MAX_POINTS - 1 < 65535) ? MAX_POINTS - 1 : 65535;
   localparam logic [IDX_W-1:0] IDX_CAP = IDX_W'(IDX_CAP_I);

   logic signed [COORD_BITS-1:0] prev_x_ff, prev_y_ff;
   logic [IDX_W-1:0]             next_index_ff, next_index_in;
   logic                         at_start_ff, at_start_in;
   logic [IDX_W-1:0]             index_w;

   // absolute difference, saturated at the delta bound
   function automatic logic [DELTA_BITS-1:0] sat_delta(
      input logic signed [COORD_BITS-1:0] a,
      input logic signed [COORD_BITS-1:0] b
   );
      logic [COORD_BITS:0] ae;
      logic [COORD_BITS:0] be;
      logic [COORD_BITS:0] d_ab;
      logic [COORD_BITS:0] d_ba;
      logic [COORD_BITS:0] mag;
      logic [AW-1:0]       mag_ext;
      ae      = {a[COORD_BITS-1], a};
      be      = {b[COORD_BITS-1], b};
      d_ab    = ae - be;
      d_ba    = be - ae;
      mag     = d_ab[COORD_BITS] ? d_ba : d_ab;
      mag_ext = AW'(mag);
      if (mag_ext > DMAX) begin
         sat_delta = DMAX[DELTA_BITS-1:0];
      end else begin
         sat_delta = mag_ext[DELTA_BITS-1:0];
      end
   endfunction

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   // index of this point and route position for the next one
   always_comb begin
      if (at_start_ff) begin
         index_w       = '0;
         next_index_in = IDX_W'(1);
      end else begin
         index_w       = next_index_ff;
         next_index_in = (next_index_ff < IDX_CAP) ? next_index_ff + 1'b1 : next_index_ff;
      end
      at_start_in = 1'b0;
      if (route_last) begin
         next_index_in = '0;
         at_start_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
         next_index_ff <= '0;
         at_start_ff   <= 1'b1;
      end else if (q_push) begin
         prev_x_ff     <= x_mm;
         prev_y_ff     <= y_mm;
         next_index_ff <= next_index_in;
         at_start_ff   <= at_start_in;
      end
   end

   // queue word
   assign q_dx        = sat_delta(x_mm, prev_x_ff);
   assign q_dy        = sat_delta(y_mm, prev_y_ff);
   assign q_tag.index = index_w;
   assign q_tag.first = at_start_ff;
   assign q_tag.last  = route_last;

endmodule

### sv/pdd_back.sv
// back end: step length by shared multiplier and bit-serial root, distance and keep decision
`include "path_distance_decimator_unit_defines.svh"

module pdd_back import pdd_pkg::*; #(
   parameter int DELTA_BITS = DELTA_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [CSR_DATA_W-1:0] spacing_mm,
   input  logic                  loop_mode,
   input  logic                  q_empty,
   output logic                  q_pop,
   input  logic [DELTA_BITS-1:0] q_dx,
   input  logic [DELTA_BITS-1:0] q_dy,
   input  pdd_tag_type           q_tag,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [IDX_W-1:0]      rsp_index,
   output logic                  rsp_selected,
   output logic                  rsp_end
);

   localparam int RW = DELTA_BITS + 1;
   localparam int VW = 2 * RW;
   localparam int SW = $clog2(RW);
   localparam int PW = 2 * DELTA_BITS;
   localparam int AW = CSR_DATA_W + 1;

   pdd_back_state_type state_ff, state_in;

   logic [DELTA_BITS-1:0] dx_ff, dy_ff;
   pdd_tag_type           tag_ff;
   logic                  kept_ff;
   logic [PW-1:0]         prod_ff;
   logic [VW-1:0]         rad_ff;
   logic [RW:0]           rem_ff;
   logic [RW-1:0]         root_ff;
   logic [SW-1:0]         cnt_ff;
   logic [CSR_DATA_W-1:0] dist_ff;
   logic                  rsp_valid_ff;
   logic [IDX_W-1:0]      rsp_index_ff;
   logic                  rsp_sel_ff, rsp_end_ff;

   logic [DELTA_BITS-1:0] mul_a;
   logic [PW-1:0]         prod_w;
   logic [RW+2:0]         rem_sh, trial, rem_sub;
   logic                  root_ge;
   logic [AW-1:0]         acc_w;
   logic [CSR_DATA_W-1:0] sat_w;
   logic                  keep_w;
   logic                  has_result, out_free, rsp_load, fast_keep;

   assign has_result = kept_ff || tag_ff.last;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fast_keep  = q_tag.first || (spacing_mm == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               state_in = fast_keep ? BK_EMIT : BK_MULX;
            end
         end
         BK_MULX:  state_in = BK_MULY;
         BK_MULY:  state_in = BK_SUM;
         BK_SUM:   state_in = BK_ROOT;
         BK_ROOT: begin
            if (cnt_ff == '0) begin
               state_in = BK_ACCUM;
            end
         end
         BK_ACCUM: state_in = BK_EMIT;
         BK_EMIT: begin
            if (!has_result || out_free) begin
               state_in = BK_IDLE;
            end
         end
         default:  state_in = BK_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      q_pop    = 1'b0;
      rsp_load = 1'b0;
      case (state_ff)
         BK_IDLE: q_pop    = !q_empty;
         BK_EMIT: rsp_load = has_result && out_free;
         default: begin
            q_pop    = 1'b0;
            rsp_load = 1'b0;
         end
      endcase
   end

   // shared squaring multiplier
   assign mul_a  = (state_ff == BK_MULY) ? dy_ff : dx_ff;
   assign prod_w = mul_a * mul_a;

   // one root bit per cycle
   assign rem_sh  = {rem_ff, rad_ff[VW-1 -: 2]};
   assign trial   = {1'b0, root_ff, 2'b01};
   assign root_ge = (rem_sh >= trial);
   assign rem_sub = root_ge ? rem_sh - trial : rem_sh;

   // saturating distance and keep test
   assign acc_w  = {1'b0, dist_ff} + AW'(root_ff);
   assign sat_w  = acc_w[CSR_DATA_W] ? '1 : acc_w[CSR_DATA_W-1:0];
   assign keep_w = (sat_w >= spacing_mm);

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         BK_IDLE: begin
            if (q_pop) begin
               dx_ff   <= q_dx;
               dy_ff   <= q_dy;
               tag_ff  <= q_tag;
               kept_ff <= fast_keep;
            end
         end
         BK_MULX: prod_ff <= prod_w;
         BK_MULY: begin
            rad_ff  <= VW'(prod_ff);
            prod_ff <= prod_w;
         end
         BK_SUM: begin
            rad_ff  <= rad_ff + VW'(prod_ff);
            rem_ff  <= '0;
            root_ff <= '0;
            cnt_ff  <= SW'(RW - 1);
         end
         BK_ROOT: begin
            rad_ff  <= {rad_ff[VW-3:0], 2'b00};
            rem_ff  <= rem_sub[RW:0];
            root_ff <= {root_ff[RW-2:0], root_ge};
            cnt_ff  <= cnt_ff - 1'b1;
         end
         BK_ACCUM: kept_ff <= keep_w;
         default: begin
         end
      endcase
   end

   // result word payload
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_index_ff <= tag_ff.index;
         rsp_sel_ff   <= kept_ff || !loop_mode;
         rsp_end_ff   <= tag_ff.last;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         dist_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (q_pop && fast_keep) begin
            dist_ff <= '0;
         end else if (state_ff == BK_ACCUM) begin
            dist_ff <= (keep_w || tag_ff.last) ? '0 : sat_w;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_index    = rsp_index_ff;
   assign rsp_selected = rsp_sel_ff;
   assign rsp_end      = rsp_end_ff;

   `PDD_ASSERT_NEXT(a_root_done, clock, reset, state_ff == BK_ROOT && cnt_ff == '0, state_ff == BK_ACCUM, "root did not finish into accumulate")
   `PDD_ASSERT_NEXT(a_root_count, clock, reset, state_ff == BK_ROOT && cnt_ff != '0, state_ff == BK_ROOT && cnt_ff == $past(cnt_ff) - 1'b1, "root step count broken")
   `PDD_ASSERT_NEXT(a_pop_path, clock, reset, q_pop, state_ff == BK_MULX || state_ff == BK_EMIT, "popped word not taken up")

endmodule

### sv/path_distance_decimator_unit.sv
// top level of the path distance decimator: register port, front, queue and back
//
// Route points enter on the req_ stream, one word per point, with req_tlast on the
// final point of a route. Each kept point, and the final point of every route,
// leaves as one word on the rsp_ stream: point index in rsp_tdata, the selected
// flag in rsp_tuser, the route end mark in rsp_tlast. Other points give no word.
// The front takes one point per cycle into a four-word queue and stalls only when
// the queue is full. The back takes one queued point at a time: the first point of
// a route, or any point with a spacing of zero, goes straight to the emit state;
// any other point passes the shared squaring multiplier, the one-bit-per-cycle
// square root and the distance accumulate. A result word is registered and appears
// in the cycle after the emit state loads it. A stalled result sits in the output
// register; the back waits on it while the front keeps filling the queue. Registers
// spacing_mm (index 0) and loop_mode (index 1) are written through csr_we, csr_addr
// and csr_wdata. Reset clears both registers, the queue and the route position.
module path_distance_decimator_unit import pdd_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int DELTA_BITS = DELTA_BITS_DEF,
   localparam int TDATA_W   = ((2 * COORD_BITS + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [TDATA_W-1:0]    req_tdata,   // x_mm, y_mm, zero fill
   input  logic                  req_tlast,   // route_last
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [IDX_W-1:0]      rsp_tdata,   // point_index
   output logic                  rsp_tuser,   // selected
   output logic                  rsp_tlast    // route_end
);

   localparam int TAG_W = $bits(pdd_tag_type);
   localparam int QW    = TAG_W + 2 * DELTA_BITS;

   logic [CSR_DATA_W-1:0] spacing_ff, spacing_in;
   logic                  loop_ff, loop_in;

   logic                  q_push, q_pop, q_full, q_empty;
   logic [DELTA_BITS-1:0] f_dx, f_dy, b_dx, b_dy;
   pdd_tag_type           f_tag, b_tag;
   logic [QW-1:0]         q_wdata, q_rdata;

   // register writes
   always_comb begin
      spacing_in = spacing_ff;
      loop_in    = loop_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_SPACING: spacing_in = csr_wdata;
            CSR_LOOP:    loop_in    = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spacing_ff <= '0;
         loop_ff    <= 1'b0;
      end else begin
         spacing_ff <= spacing_in;
         loop_ff    <= loop_in;
      end
   end

   pdd_front #(
      .MAX_POINTS(MAX_POINTS),
      .COORD_BITS(COORD_BITS),
      .DELTA_BITS(DELTA_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .x_mm       (req_tdata[COORD_BITS-1:0]),
      .y_mm       (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .route_last (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_dx       (f_dx),
      .q_dy       (f_dy),
      .q_tag      (f_tag)
   );

   // queue word packing
   assign q_wdata = {f_tag, f_dx, f_dy};
   assign b_tag   = q_rdata[QW-1 -: TAG_W];
   assign b_dx    = q_rdata[2*DELTA_BITS-1:DELTA_BITS];
   assign b_dy    = q_rdata[DELTA_BITS-1:0];

   pdd_fifo #(
      .WIDTH(QW),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .full      (q_full),
      .empty     (q_empty)
   );

   pdd_back #(
      .DELTA_BITS(DELTA_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .spacing_mm   (spacing_ff),
      .loop_mode    (loop_ff),
      .q_empty      (q_empty),
      .q_pop        (q_pop),
      .q_dx         (b_dx),
      .q_dy         (b_dy),
      .q_tag        (b_tag),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_index    (rsp_tdata),
      .rsp_selected (rsp_tuser),
      .rsp_end      (rsp_tlast)
   );

endmodule

### sim/pdd_result_checker.sv
// result checker for the path distance decimator: predicts each result word and compares
module pdd_result_checker import pdd_pkg::*; #(
   parameter int TDATA_W = ((2 * COORD_BITS_DEF + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [TDATA_W-1:0]    req_tdata,
   input  logic                  req_tlast,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [IDX_W-1:0]      rsp_tdata,
   input  logic                  rsp_tuser,
   input  logic                  rsp_tlast,
   output int                    mismatches,
   output int                    waiting
);

   localparam longint DELTA_LIMIT = (longint'(1) << DELTA_BITS_DEF) - 1;
   localparam int INDEX_CAP = (MAX_POINTS_DEF - 1 < 65535) ? MAX_POINTS_DEF - 1 : 65535;

   // one result word as it should leave the block
   typedef struct packed {
      logic [IDX_W-1:0] index;
      logic             selected;
      logic             route_end;
   } point_mark_type;

   point_mark_type pending_marks[$];

   // register copies and route position
   logic [31:0]      spacing_q;
   logic             loop_q;
   logic [31:0]      last_x;
   logic [31:0]      last_y;
   logic [31:0]      travelled;
   logic [IDX_W-1:0] index_next;
   logic             route_fresh;

   // magnitude of a coordinate difference, clipped to the delta bound
   function automatic logic [63:0] clamped_delta(logic [31:0] a, logic [31:0] b);
      longint d;
      d = longint'(signed'(a)) - longint'(signed'(b));
      if (d < 0)
         d = -d;
      if (d > DELTA_LIMIT)
         d = DELTA_LIMIT;
      return 64'(d);
   endfunction

   // floor of the square root, two bits of the radicand per pass
   function automatic logic [31:0] floor_root(logic [63:0] radicand);
      logic [63:0] rest;
      logic [63:0] root;
      logic [63:0] probe;
      rest  = radicand;
      root  = '0;
      probe = 64'd1 << 62;
      while (probe > rest)
         probe = probe >> 2;
      while (probe != 0) begin
         if (rest >= root + probe) begin
            rest = rest - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root[31:0];
   endfunction

   // advance the route by one point and queue the word it causes, if any
   task automatic decimate_point(input logic [31:0] x, input logic [31:0] y,
                                 input logic last);
      logic [IDX_W-1:0] idx;
      logic             kept;
      logic [63:0]      dx;
      logic [63:0]      dy;
      logic [32:0]      sum;
      point_mark_type   mark;
      if (route_fresh) begin
         idx        = '0;
         kept       = 1'b1;
         travelled  = '0;
         index_next = IDX_W'(1);
      end else begin
         idx = index_next;
         if (index_next < INDEX_CAP)
            index_next = index_next + 1'b1;
         if (spacing_q == 0) begin
            kept = 1'b1;
         end else begin
            dx        = clamped_delta(x, last_x);
            dy        = clamped_delta(y, last_y);
            sum       = {1'b0, travelled} + floor_root(dx * dx + dy * dy);
            travelled = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            kept      = travelled >= spacing_q;
         end
         if (kept)
            travelled = '0;
      end
      route_fresh = 1'b0;
      last_x      = x;
      last_y      = y;
      if (kept) begin
         mark = '{idx, 1'b1, last};
         pending_marks.insert(pending_marks.size(), mark);
      end else if (last) begin
         mark = '{idx, !loop_q, 1'b1};
         pending_marks.insert(pending_marks.size(), mark);
      end
      if (last) begin
         route_fresh = 1'b1;
         travelled   = '0;
         index_next  = '0;
      end
   endtask

   // follow register writes, predict on each accepted point, check each result word
   always @(posedge clock) begin : watch
      point_mark_type seen;
      point_mark_type want;
      if (reset) begin
         spacing_q   = '0;
         loop_q      = 1'b0;
         last_x      = '0;
         last_y      = '0;
         travelled   = '0;
         index_next  = '0;
         route_fresh = 1'b1;
         pending_marks.delete();
      end else begin
         if (csr_we) begin
            if (csr_addr == CSR_SPACING)
               spacing_q = csr_wdata;
            else if (csr_addr == CSR_LOOP)
               loop_q = csr_wdata[0];
         end
         if (req_tvalid && req_tready)
            decimate_point(req_tdata[31:0], req_tdata[63:32], req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            seen = '{rsp_tdata, rsp_tuser, rsp_tlast};
            if (pending_marks.size() == 0) begin
               $display("%0t: unexpected word, expected none, got %p", $time, seen);
               mismatches = mismatches + 1;
            end else begin
               want = pending_marks.pop_front();
               if (seen != want) begin
                  $display("%0t: word mismatch, expected %p, got %p", $time, want, seen);
                  mismatches = mismatches + 1;
               end
            end
         end
      end
      waiting = pending_marks.size();
   end

endmodule

### sim/testbench.sv
// top of the path distance decimator testbench: clock, reset, point stimulus and verdict
module testbench import pdd_pkg::*;;

   localparam int TDATA_W         = ((2 * COORD_BITS_DEF + 7) / 8) * 8;
   localparam int SETTLE_CYCLES   = 256;
   localparam int HOLD_CYCLES     = 600;
   localparam int WATCHDOG_LIMIT  = 4000;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [TDATA_W-1:0]    req_tdata;   // x_mm, y_mm
   logic                  req_tlast;   // route_last
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [IDX_W-1:0]      rsp_tdata;   // point_index
   logic                  rsp_tuser;   // selected
   logic                  rsp_tlast;   // route_end

   int failures;
   int outstanding;
   int quiet_cycles;
   bit req_gaps;
   bit rsp_gaps;
   bit hold_rsp;

   path_distance_decimator_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   pdd_result_checker #(.TDATA_W(TDATA_W)) result_check (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .mismatches (failures),
      .waiting    (outstanding)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog on cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   // result receiver: random stall bursts and one long hold-off on request
   initial begin : receiver
      int burst;
      rsp_tready <= 1'b1;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
            rsp_tready <= 1'b1;
         end else if (rsp_gaps && $urandom_range(0, 4) == 0) begin
            burst = $urandom_range(1, 13);
            rsp_tready <= 1'b0;
            repeat (burst) @(negedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   // offer one point and hold it until accepted
   task automatic push_point(input logic [31:0] x, input logic [31:0] y, input logic last);
      int gap;
      if (req_gaps && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 13);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {y, x};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // drain every expected word, then let points that give no word clear the block
   task automatic settle();
      req_tvalid <= 1'b0;
      while (outstanding != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_mode(input logic [31:0] spacing, input logic [31:0] loop_word);
      settle();
      csr_write(CSR_SPACING, spacing);
      csr_write(CSR_LOOP, loop_word);
   endtask

   // random routes: mostly walks with steps up to reach, some jumps and repeats
   task automatic run_routes(input int budget, input int reach, input int max_len,
                             input bit idling_ok);
      int          left;
      int          len;
      int          k;
      logic [31:0] x;
      logic [31:0] y;
      left = budget;
      while (left > 0) begin
         len = $urandom_range(1, max_len);
         if (len > left)
            len = left;
         req_gaps = idling_ok && $urandom_range(0, 3) != 0;
         rsp_gaps = idling_ok && $urandom_range(0, 3) != 0;
         x = $urandom;
         y = $urandom;
         for (k = 0; k < len; k++) begin
            if (k > 0) begin
               case ($urandom_range(0, 9))
                  0: begin
                     x = $urandom;
                     y = $urandom;
                  end
                  1: ;
                  default: begin
                     x = x + ($urandom_range(0, 2 * reach) - reach);
                     y = y + ($urandom_range(0, 2 * reach) - reach);
                  end
               endcase
            end
            push_point(x, y, k == len - 1);
         end
         left = left - len;
      end
   endtask

   initial begin : stimulus
      int          phase;
      int          budget;
      int          reach;
      int          max_len;
      logic [31:0] spacing;
      logic [31:0] loop_word;
      reset      <= 1'b1;
      csr_we     <= 1'b0;
      csr_addr   <= CSR_SPACING;
      csr_wdata  <= '0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      req_gaps   = 1'b1;
      rsp_gaps   = 1'b1;
      hold_rsp   = 1'b0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // open route, spacing 1000, loop word with upper bits set
      set_mode(32'd1000, 32'hFFFF_FFFE);
      push_point(0, 0, 1'b1);                          // single-point route
      push_point(0, 0, 1'b0);
      push_point(600, 0, 1'b0);
      push_point(1200, 0, 1'b0);                       // distance reaches spacing
      push_point(1300, 0, 1'b1);                       // open end forced
      push_point(0, 0, 1'b0);
      push_point(600, 800, 1'b1);                      // exactly the spacing on the end
      push_point(32'h8000_0000, 32'h8000_0000, 1'b0);  // coordinate extremes, clipped deltas
      push_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      push_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      push_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);

      // closed route, largest spacing: unkept end
      set_mode(32'hFFFF_FFFF, 32'd1);
      push_point(0, 0, 1'b0);
      push_point(10, 10, 1'b0);
      push_point(20, 20, 1'b1);
      push_point(5, 5, 1'b1);

      // spacing zero keeps all
      set_mode(32'd0, 32'h8000_0001);
      push_point(1, 2, 1'b0);
      push_point(1, 2, 1'b0);
      push_point(-7, 3, 1'b1);

      // spacing one with a zero step
      set_mode(32'd1, 32'd1);
      push_point(0, 0, 1'b0);
      push_point(0, 0, 1'b0);
      push_point(1, 0, 1'b1);

      // random phases over several settings
      for (phase = 0; phase < 7; phase++) begin
         budget  = 210;
         max_len = 30;
         case (phase)
            0: begin
               spacing = $urandom_range(1, 3000);
               reach   = 1500;
            end
            1: begin
               spacing = 0;
               reach   = 1500;
            end
            2: begin
               spacing = $urandom;
               reach   = 1 << 25;
            end
            3: begin
               // long routes of big steps push the distance into saturation
               spacing = 32'hFFFF_FFFF;
               reach   = 1 << 26;
               budget  = 450;
               max_len = 400;
            end
            4: begin
               spacing = 1;
               reach   = 16;
            end
            5: begin
               spacing = 0;
               reach   = 0;
            end
            default: begin
               spacing = $urandom_range(1, 100000);
               reach   = 1 << 16;
            end
         endcase
         loop_word = ($urandom & ~32'd1) | $urandom_range(0, 1);
         set_mode(spacing, loop_word);
         if (phase == 0)
            hold_rsp = 1'b1;
         run_routes(budget, reach, max_len, phase < 6);
      end

      settle();
      if (failures == 0 && outstanding == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

### filelist.f
+incdir+sv
sv/pdd_pkg.sv
sv/pdd_fifo.sv
sv/pdd_front.sv
sv/pdd_back.sv
sv/path_distance_decimator_unit.sv
sim/pdd_result_checker.sv
sim/testbench.sv
